@@ hdl/alpl_pkg.sv @@
`default_nettype none

package alpl_pkg;

  localparam int unsigned DefaultCapacity = 128;

  localparam logic [2:0] OP_ADD_BACK   = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_READ_FRONT = 3'd3;
  localparam logic [2:0] OP_REMOVE     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND_FREE,
    ST_INS_LINK,
    ST_POP_RD,
    ST_FRONT_RD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_RESP
  } alpl_state_e;

endpackage

`default_nettype wire

@@ hdl/array_linked_point_list_core.sv @@
// Doubly linked list of (x,y) points held in slot memories.
// Input channel (in_valid_i/in_ready_o) carries op, point_x, point_y; each
// transfer gives exactly one result on the output channel (out_valid_o /
// out_ready_i): ok, front_x, front_y (nonzero only on a read of the front)
// and the count after the operation.
// One operation is worked at a time; in_ready_o is high while the engine is
// idle, even while a finished result still waits in the output register.
// Steps per operation: an unknown op, or a failing op on a full/empty list,
// goes straight to the response; pop and read front read the head slot first;
// insert finds the lowest free slot by walking the occupied flags one slot a
// cycle, writes it, and then links it in when the list was not empty; remove
// reads each occupied slot and then compares it (one memory read, one compare),
// skipping free slots, until the match or the last slot.
// Reset clears the occupied flags, head, tail and count at once; point and
// link memories are not cleared. When the receiver stalls, a finished result
// waits in a holding register until the output register frees up.
`default_nettype none

module array_linked_point_list_core
  import alpl_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         op_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    ok_o,
  output logic signed [31:0]      front_x_o,
  output logic signed [31:0]      front_y_o,
  output logic [7:0]              count_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LastSlot = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] FullCount = CW'(CAPACITY);

  logic [31:0]   x_mem [CAPACITY];
  logic [31:0]   y_mem [CAPACITY];
  logic [IW-1:0] nx_mem [CAPACITY];
  logic [IW-1:0] pv_mem [CAPACITY];

  alpl_state_e state_q, state_d;
  logic [2:0]          op_q, op_d;
  logic [31:0]         px_q, px_d, py_q, py_d;
  logic [IW-1:0]       scan_q, scan_d, slot_q, slot_d;
  logic [IW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CAPACITY-1:0] occ_q, occ_d;
  logic                res_ok_q, res_ok_d;
  logic [31:0]         res_x_q, res_x_d, res_y_q, res_y_d;
  logic                out_valid_q, out_valid_d;
  logic                ok_q, ok_d;
  logic [31:0]         fx_q, fx_d, fy_q, fy_d;
  logic [CW-1:0]       ocnt_q, ocnt_d;

  logic [IW-1:0] rd_addr;
  logic [31:0]   x_rd, y_rd;
  logic [IW-1:0] nx_rd, pv_rd;

  logic          xy_we;
  logic          nx_we, pv_we;
  logic [IW-1:0] nx_wa, pv_wa, nx_wd, pv_wd;

  logic in_xfer, out_free, is_empty, is_full, match, scan_last;
  logic [CW+7:0] cnt_ext;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign is_empty   = (cnt_q == '0);
  assign is_full    = (cnt_q >= FullCount);
  assign match      = (x_rd == px_q) && (y_rd == py_q);
  assign scan_last  = (scan_q == LastSlot);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (op_i)
            OP_ADD_BACK, OP_PUSH_FRONT: state_d = is_full ? ST_RESP : ST_FIND_FREE;
            OP_POP_FRONT:  state_d = is_empty ? ST_RESP : ST_POP_RD;
            OP_READ_FRONT: state_d = is_empty ? ST_RESP : ST_FRONT_RD;
            OP_REMOVE:     state_d = is_empty ? ST_RESP : ST_SCAN_RD;
            default:       state_d = ST_RESP;
          endcase
        end
      end
      ST_FIND_FREE: begin
        if (!occ_q[scan_q]) state_d = is_empty ? ST_RESP : ST_INS_LINK;
      end
      ST_INS_LINK: state_d = ST_RESP;
      ST_POP_RD:   state_d = ST_RESP;
      ST_FRONT_RD: state_d = ST_RESP;
      ST_SCAN_RD: begin
        if (occ_q[scan_q])  state_d = ST_SCAN_CMP;
        else if (scan_last) state_d = ST_RESP;
      end
      ST_SCAN_CMP: begin
        if (match || scan_last) state_d = ST_RESP;
        else                    state_d = ST_SCAN_RD;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    op_d     = op_q;
    px_d     = px_q;
    py_d     = py_q;
    scan_d   = scan_q;
    slot_d   = slot_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    occ_d    = occ_q;
    res_ok_d = res_ok_q;
    res_x_d  = res_x_q;
    res_y_d  = res_y_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ok_d     = ok_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    ocnt_d   = ocnt_q;
    rd_addr  = head_q;
    xy_we    = 1'b0;
    nx_we    = 1'b0;
    pv_we    = 1'b0;
    nx_wa    = scan_q;
    pv_wa    = scan_q;
    nx_wd    = scan_q;
    pv_wd    = scan_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d     = op_i;
          px_d     = point_x_i;
          py_d     = point_y_i;
          scan_d   = '0;
          res_ok_d = 1'b0;
          res_x_d  = '0;
          res_y_d  = '0;
        end
      end
      ST_FIND_FREE: begin
        if (!occ_q[scan_q]) begin
          xy_we = 1'b1;
          nx_we = 1'b1;
          pv_we = 1'b1;
          if (!is_empty && op_q == OP_PUSH_FRONT) nx_wd = head_q;
          if (!is_empty && op_q == OP_ADD_BACK)   pv_wd = tail_q;
          occ_d[scan_q] = 1'b1;
          slot_d = scan_q;
          if (is_empty) begin
            head_d   = scan_q;
            tail_d   = scan_q;
            cnt_d    = cnt_q + 1'b1;
            res_ok_d = 1'b1;
          end
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_INS_LINK: begin
        if (op_q == OP_PUSH_FRONT) begin
          pv_we  = 1'b1;
          pv_wa  = head_q;
          pv_wd  = slot_q;
          head_d = slot_q;
        end else begin
          nx_we  = 1'b1;
          nx_wa  = tail_q;
          nx_wd  = slot_q;
          tail_d = slot_q;
        end
        cnt_d    = cnt_q + 1'b1;
        res_ok_d = 1'b1;
      end
      ST_POP_RD: begin
        occ_d[head_q] = 1'b0;
        head_d   = nx_rd;
        cnt_d    = cnt_q - 1'b1;
        res_ok_d = 1'b1;
      end
      ST_FRONT_RD: begin
        res_x_d  = x_rd;
        res_y_d  = y_rd;
        res_ok_d = 1'b1;
      end
      ST_SCAN_RD: begin
        rd_addr = scan_q;
        if (!occ_q[scan_q] && !scan_last) scan_d = scan_q + 1'b1;
      end
      ST_SCAN_CMP: begin
        if (match) begin
          // unlink: pv_rd/nx_rd are this slot's neighbors
          occ_d[scan_q] = 1'b0;
          if (scan_q == head_q) begin
            head_d = nx_rd;
          end else begin
            nx_we = 1'b1;
            nx_wa = pv_rd;
            nx_wd = nx_rd;
          end
          if (scan_q == tail_q) begin
            tail_d = pv_rd;
          end else begin
            pv_we = 1'b1;
            pv_wa = nx_rd;
            pv_wd = pv_rd;
          end
          cnt_d    = cnt_q - 1'b1;
          res_ok_d = 1'b1;
        end else if (!scan_last) begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ok_d   = res_ok_q;
          fx_d   = res_x_q;
          fy_d   = res_y_q;
          ocnt_d = cnt_q;
        end
      end
      default: ;
    endcase
    if (state_q == ST_IDLE && in_xfer && op_i == OP_POP_FRONT) rd_addr = head_q;
  end

  always_ff @(posedge clk_i) begin
    if (xy_we) begin
      x_mem[scan_q] <= px_q;
      y_mem[scan_q] <= py_q;
    end
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    x_rd  <= x_mem[rd_addr];
    y_rd  <= y_mem[rd_addr];
    nx_rd <= nx_mem[rd_addr];
    pv_rd <= pv_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    px_q     <= px_d;
    py_q     <= py_d;
    scan_q   <= scan_d;
    slot_q   <= slot_d;
    res_ok_q <= res_ok_d;
    res_x_q  <= res_x_d;
    res_y_q  <= res_y_d;
    ok_q     <= ok_d;
    fx_q     <= fx_d;
    fy_q     <= fy_d;
    ocnt_q   <= ocnt_d;
  end

  assign cnt_ext     = {8'b0, ocnt_q};
  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign front_x_o   = fx_q;
  assign front_y_o   = fy_q;
  assign count_o     = cnt_ext[7:0];

endmodule

`default_nettype wire
